// File: rtl/core/wlh_pkg.sv
// shared types and constants for the wake-up latency histogram
package wlh_pkg;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_WAKE  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] CFG_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_RUN      = 2'd1;

    localparam int         INTERVAL_W  = 30;
    localparam int         RUN_W       = 12;
    localparam int         CFG_IDX_W   = 2;
    localparam int         PROD_W      = RUN_W + INTERVAL_W;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 30'd1000000;
    localparam logic [RUN_W-1:0]      RUN_RST      = 12'd10;
    localparam logic [INTERVAL_W-1:0] NS_PER_S     = 30'd1000000000;

    localparam int         DIV_W       = 64;
    localparam int         QUOT_W      = 32;
    localparam int         HALF_W      = 20;
    localparam int         NUM_LSB     = 3;
    localparam int         NUM_MID     = NUM_LSB + HALF_W;
    localparam int         NUM_MSB     = 41;
    localparam int         ACC_W       = 79;
    localparam int         RECIP_SHIFT = 46;
    localparam logic [2*HALF_W-1:0] RECIP_125 = 40'd562949953422;
    localparam logic [DIV_W-1:0]    SAT_NS    = 64'd4294967296000;
    localparam int         DIV_STEPS   = 4;
    localparam int         DIV_CNT_W   = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [1:0]  kind;
        logic [62:0] now_ns;
        logic [14:0] bin_index;
    } wlh_in_t;

    typedef struct packed {
        logic [31:0] bin_count;
        logic [31:0] late_us;
        logic [31:0] sample_total;
        logic [31:0] overflow_total;
        logic [31:0] max_latency_us;
        logic        finished;
    } wlh_out_t;

endpackage

// File: rtl/core/wlh_ram.sv
// generic single-write single-read ram with registered read data
module wlh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 20000
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/wlh_div.sv
// divide of a 64-bit nanosecond count by 1000 through reciprocal multiplication, saturated to 32 bits
module wlh_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [wlh_pkg::DIV_W-1:0]     dividend,
    output logic                          done,
    output logic [wlh_pkg::QUOT_W-1:0]    quotient
);

    import wlh_pkg::*;

    logic [DIV_W-1:0]     num_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic                 sat_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [HALF_W-1:0]    mul_a;
    logic [HALF_W-1:0]    mul_b;
    logic [2*HALF_W-1:0]  part;
    logic [ACC_W-1:0]     part_ext;
    logic [ACC_W-1:0]     acc_next;

    // x / 1000 = (x / 8) / 125, one half by half product per step
    always_comb
    begin
        mul_a = cnt_reg[1] ? HALF_W'(num_reg[NUM_MSB:NUM_MID])
                           : num_reg[NUM_MID-1:NUM_LSB];
        mul_b = cnt_reg[0] ? RECIP_125[2*HALF_W-1:HALF_W] : RECIP_125[HALF_W-1:0];
        part  = mul_a * mul_b;
        case (cnt_reg)
            2'd0:       part_ext = ACC_W'(part);
            2'd1, 2'd2: part_ext = ACC_W'(part) << HALF_W;
            default:    part_ext = ACC_W'(part) << (2 * HALF_W);
        endcase
        acc_next = acc_reg + part_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            sat_reg <= num_reg >= SAT_NS;
        end
    end

    assign done     = done_reg;
    assign quotient = sat_reg ? '1 : acc_reg[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divide started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divide done without a running divide");

    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && cnt_reg != DIV_CNT_W'(DIV_STEPS - 1)) |=> busy_reg)
        else $error("divide stopped early");
`endif

endmodule

// File: rtl/core/wakeup_latency_histogram_top.sv
// top level of the wake-up latency histogram monitor
// After reset the bin memory is swept to zero, one bin per clock, so no item is
// accepted until the sweep has covered all BIN_COUNT bins (configuration writes are
// taken at any time). Items are handled one at a time. The time a wake-up item
// takes from acceptance to the next acceptance is set by the divide of the lateness
// by 1000, a reciprocal multiplication with one 20 by 20 bit product per cycle,
// then a step that presents the quotient and reads the bin memory, followed by one
// write of the bin memory. A finished result sits in an output register, so the
// next item can be taken while the result waits.
module wakeup_latency_histogram_top #(
    parameter int BIN_COUNT = 20000
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  wlh_pkg::wlh_in_t                   req_data,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output wlh_pkg::wlh_out_t                  rsp_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wlh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wlh_pkg::INTERVAL_W-1:0]     cfg_data
);

    import wlh_pkg::*;

    localparam int AW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_CALC  = 7'b0000100,
        S_START = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_WR    = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t                state_reg;
    state_t                state_next;

    logic [INTERVAL_W-1:0] interval_reg;
    logic [RUN_W-1:0]      run_reg;

    logic [63:0]           deadline_reg;
    logic [63:0]           stop_reg;
    logic [31:0]           overflow_reg;
    logic [31:0]           sample_reg;
    logic [31:0]           max_reg;
    logic [AW-1:0]         clr_reg;

    logic [1:0]            kind_reg;
    logic [62:0]           now_reg;
    logic [AW-1:0]         idx_reg;
    logic                  inbin_reg;
    logic                  fin_reg;
    logic                  restart_reg;
    logic [63:0]           late_ns_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [31:0]           lat_reg;
    logic [31:0]           bin_val_reg;

    logic                  rsp_valid_reg;
    wlh_out_t              rsp_reg;

    logic                  accept;
    logic                  rsp_load;
    logic [63:0]           now_ext;
    logic                  late_pos;
    logic [63:0]           diff_ns;
    logic [16:0]           idx_ext;
    logic                  idx_inbin;
    logic [PROD_W-1:0]     prod_next;
    logic                  div_start;
    logic                  div_done;
    logic [QUOT_W-1:0]     div_quot;
    logic [31:0]           lat_next;
    logic                  lat_inbin;
    logic [31:0]           bin_rdata;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [31:0]           ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [63:0]           deadline_base;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_load  = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);

    assign now_ext   = {1'b0, now_reg};
    assign late_pos  = now_ext > deadline_reg;
    assign diff_ns   = now_ext - deadline_reg;
    assign idx_ext   = {2'b00, req_data.bin_index};
    assign idx_inbin = idx_ext < 17'(BIN_COUNT);
    assign prod_next = run_reg * NS_PER_S;

    assign div_start = (state_reg == S_CALC) && (kind_reg == KIND_WAKE);
    assign lat_next  = div_quot;
    assign lat_inbin = lat_next < 32'(BIN_COUNT);

    assign deadline_base = restart_reg ? now_ext : deadline_reg;

    // bin memory port steering
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = lat_reg[AW-1:0];
        ram_wdata = sat_inc(bin_rdata);
        ram_re    = 1'b0;
        ram_raddr = idx_reg;
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else if (state_reg == S_WR)
        begin
            ram_we = (kind_reg == KIND_WAKE) && inbin_reg;
        end
        if (state_reg == S_CALC)
        begin
            ram_re = (kind_reg == KIND_READ) && inbin_reg;
        end
        else if (state_reg == S_DIV)
        begin
            ram_re    = div_done && lat_inbin;
            ram_raddr = lat_next[AW-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == AW'(BIN_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                case (kind_reg)
                    KIND_START: state_next = S_START;
                    KIND_WAKE:  state_next = S_DIV;
                    KIND_READ:  state_next = S_WR;
                    default:    state_next = S_DONE;
                endcase
            end
            S_START:
            begin
                state_next = S_DONE;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            interval_reg <= INTERVAL_RST;
            run_reg      <= RUN_RST;
            deadline_reg <= '0;
            stop_reg     <= '0;
            overflow_reg <= '0;
            sample_reg   <= '0;
            max_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_INTERVAL: interval_reg <= cfg_data;
                    CFG_RUN:      run_reg      <= cfg_data[RUN_W-1:0];
                    default:      ;
                endcase
            end
            if (state_reg == S_START)
            begin
                deadline_reg <= now_ext + {34'd0, interval_reg};
                stop_reg     <= now_ext + {22'd0, prod_reg};
            end
            if ((state_reg == S_WR) && (kind_reg == KIND_WAKE))
            begin
                if (lat_reg > max_reg)
                begin
                    max_reg <= lat_reg;
                end
                if (!inbin_reg)
                begin
                    overflow_reg <= sat_inc(overflow_reg);
                end
                sample_reg   <= sat_inc(sample_reg);
                deadline_reg <= deadline_base + {34'd0, interval_reg};
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= req_data.kind;
            now_reg   <= req_data.now_ns;
            idx_reg   <= idx_ext[AW-1:0];
            inbin_reg <= idx_inbin;
        end
        if (state_reg == S_CALC)
        begin
            fin_reg     <= now_ext >= stop_reg;
            late_ns_reg <= late_pos ? diff_ns : '0;
            prod_reg    <= prod_next;
        end
        if (state_reg == S_DIV)
        begin
            restart_reg <= late_ns_reg > {34'd0, interval_reg};
            if (div_done)
            begin
                lat_reg   <= lat_next;
                inbin_reg <= lat_inbin;
            end
        end
        if (state_reg == S_WR)
        begin
            bin_val_reg <= inbin_reg ? bin_rdata : '0;
        end
        if (rsp_load)
        begin
            rsp_reg.bin_count      <= (kind_reg == KIND_READ) ? bin_val_reg : '0;
            rsp_reg.late_us        <= (kind_reg == KIND_WAKE) ? lat_reg : '0;
            rsp_reg.sample_total   <= sample_reg;
            rsp_reg.overflow_total <= overflow_reg;
            rsp_reg.max_latency_us <= max_reg;
            rsp_reg.finished       <= (kind_reg == KIND_WAKE) && fin_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    wlh_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (late_pos ? diff_ns : 64'd0),
        .done     (div_done),
        .quotient (div_quot)
    );

    wlh_ram #(
        .WIDTH (32),
        .DEPTH (BIN_COUNT)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (bin_rdata)
    );

`ifndef SYNTHESIS
    a_counters_only_in_wr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_WR) |=> ($stable(sample_reg) && $stable(overflow_reg)
                                 && $stable(max_reg)))
        else $error("counters changed outside the update step");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divide finished outside the divide state");

    a_ram_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_WR))
        else $error("bin memory written outside clear or update");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |=> (rsp_valid_reg && state_reg == S_IDLE))
        else $error("result not presented after completion");
`endif

endmodule
